FILE: hw/rtl/led_edge_pixel_remap_top_macros.svh
// Assertion macros for the LED edge pixel remap block.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef LED_EDGE_PIXEL_REMAP_TOP_MACROS_SVH
`define LED_EDGE_PIXEL_REMAP_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LEPR_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lepr: assertion failed");

// antecedent implies consequent in the next cycle
`define LEPR_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lepr: assertion failed");

`endif

FILE: hw/rtl/lepr_pkg.sv
// Package for the LED edge pixel remap block: field widths, codes, table entry type,
// and the sequencer microcode ROM. No dependencies.
`default_nettype none

package lepr_pkg;

    localparam int MAX_EDGES_DEF   = 64;
    localparam int PIXEL_WIDTH_DEF = 14;

    localparam int OP_W   = 2;
    localparam int EDGE_W = 6;
    localparam int LEDS_W = 8;
    localparam int SLOT_W = 6;
    localparam int PIX_W  = 14;
    localparam int CFG_W  = 7;
    localparam int DIR_W  = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_QEDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_QPIX  = 2'd2;

    localparam logic signed [DIR_W-1:0] DIR_FWD = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_REV = 2'sb11;

    typedef struct packed {
        logic [LEDS_W-1:0] leds;
        logic [SLOT_W-1:0] slot;
        logic              flip;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EQ_READ,
        ST_EQ_LATCH,
        ST_WALK,
        ST_WALK_SEL,
        ST_SUM,
        ST_SUM_DRAIN,
        ST_EMIT,
        ST_EMIT_ZERO
    } t_step;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_REQ,
        C_EDGE_OOR,
        C_WALK_STOP,
        C_NO_HIT,
        C_SUM_DONE,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_RD_EDGE,
        A_LATCH_Q,
        A_WALK,
        A_LATCH_HIT,
        A_SUM,
        A_EMIT,
        A_EMIT_ZERO
    } t_act;

    // cond true: go to jmp, action suppressed; else run act and go to nxt, or to op_entry for accept
    typedef struct packed {
        t_cond cond;
        t_act  act;
        t_step jmp;
        t_step nxt;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            ST_IDLE:      w = '{cond: C_NO_REQ,    act: A_ACCEPT,    jmp: ST_IDLE,
                                nxt: ST_IDLE};
            ST_EQ_READ:   w = '{cond: C_EDGE_OOR,  act: A_RD_EDGE,   jmp: ST_EMIT_ZERO,
                                nxt: ST_EQ_LATCH};
            ST_EQ_LATCH:  w = '{cond: C_NEVER,     act: A_LATCH_Q,   jmp: ST_IDLE,
                                nxt: ST_SUM};
            ST_WALK:      w = '{cond: C_WALK_STOP, act: A_WALK,      jmp: ST_WALK_SEL,
                                nxt: ST_WALK};
            ST_WALK_SEL:  w = '{cond: C_NO_HIT,    act: A_LATCH_HIT, jmp: ST_EMIT_ZERO,
                                nxt: ST_SUM};
            ST_SUM:       w = '{cond: C_SUM_DONE,  act: A_SUM,       jmp: ST_SUM_DRAIN,
                                nxt: ST_SUM};
            ST_SUM_DRAIN: w = '{cond: C_NEVER,     act: A_NONE,      jmp: ST_IDLE,
                                nxt: ST_EMIT};
            ST_EMIT:      w = '{cond: C_OUT_BUSY,  act: A_EMIT,      jmp: ST_EMIT,
                                nxt: ST_IDLE};
            ST_EMIT_ZERO: w = '{cond: C_OUT_BUSY,  act: A_EMIT_ZERO, jmp: ST_EMIT_ZERO,
                                nxt: ST_IDLE};
            default:      w = '{cond: C_NO_REQ,    act: A_ACCEPT,    jmp: ST_IDLE,
                                nxt: ST_IDLE};
        endcase
        return w;
    endfunction

    // entry point of the program for an accepted request
    function automatic t_step op_entry(input logic [OP_W-1:0] op);
        t_step s;
        case (op)
            OP_QEDGE: s = ST_EQ_READ;
            OP_QPIX:  s = ST_WALK;
            default:  s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/led_edge_pixel_remap_top.sv
// LED edge pixel remap: edge table memory, microcoded sequencer and datapath.
// Depends on lepr_pkg and led_edge_pixel_remap_top_macros.svh.
// Writes, edge queries and pixel queries are served one request at a time, set by the
// single table read port.
// Reset (sync, active low): sequencer idle, output empty, edge_count = 64; tables read as
// reset values through per-entry valid flags, so no clearing pass is needed.
`default_nettype none
`include "led_edge_pixel_remap_top_macros.svh"

module led_edge_pixel_remap_top #(
    parameter int MAX_EDGES   = lepr_pkg::MAX_EDGES_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  [lepr_pkg::OP_W-1:0]            i_operation,
    input  wire  [lepr_pkg::EDGE_W-1:0]          i_edge_index,
    input  wire  [lepr_pkg::LEDS_W-1:0]          i_led_total,
    input  wire  [lepr_pkg::SLOT_W-1:0]          i_strip_slot,
    input  wire                                  i_reverse,
    input  wire  [lepr_pkg::PIX_W-1:0]           i_pixel_index,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [lepr_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [lepr_pkg::EDGE_W-1:0]          o_found_edge,
    output logic [lepr_pkg::PIX_W-1:0]           o_start_index,
    output logic [lepr_pkg::LEDS_W-1:0]          o_edge_leds,
    output logic signed [lepr_pkg::DIR_W-1:0]    o_direction,
    output logic [lepr_pkg::PIX_W-1:0]           o_phys_index,
    output logic                                 o_valid_res
);

    localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW   = $clog2(MAX_EDGES + 1);
    localparam int SUMW = $clog2(MAX_EDGES * (2 ** lepr_pkg::LEDS_W - 1) + 1);
    localparam int HW   = ((SUMW > lepr_pkg::PIX_W) ? SUMW : lepr_pkg::PIX_W) + 1;
    localparam int IW   = ((CW > lepr_pkg::CFG_W) ? CW : lepr_pkg::CFG_W) + 1;

    // sequencer
    lepr_pkg::t_step  r_step;
    lepr_pkg::t_step  n_step;
    lepr_pkg::t_uword w_uw;
    logic             w_cond;
    logic             w_fire;

    // table memory
    lepr_pkg::t_entry r_mem [MAX_EDGES];
    logic [MAX_EDGES-1:0] r_vld;
    lepr_pkg::t_entry r_rd_data;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_addr;
    lepr_pkg::t_entry w_rd;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic             w_wr_en;
    lepr_pkg::t_entry w_wr_data;

    // datapath
    logic [lepr_pkg::CFG_W-1:0]  r_cfg;
    logic [lepr_pkg::EDGE_W-1:0] r_edge;
    logic [lepr_pkg::PIX_W-1:0]  r_pix;
    logic                        r_is_pix;
    logic [CW-1:0]               r_scan;
    logic [SUMW-1:0]             r_acc;
    logic [SUMW-1:0]             r_base;
    logic                        r_walk_pend;
    logic                        r_sum_pend;
    logic [lepr_pkg::LEDS_W-1:0] r_cnt;
    logic [lepr_pkg::SLOT_W-1:0] r_slot;
    logic                        r_flip;
    logic [lepr_pkg::LEDS_W-1:0] r_pos;
    logic                        r_o_valid;

    logic [IW-1:0]               w_n;
    logic                        w_hit;
    logic [HW-1:0]               w_off_full;
    logic [lepr_pkg::LEDS_W-1:0] w_off;
    logic [lepr_pkg::PIX_W-1:0]  w_start;
    logic [lepr_pkg::PIX_W-1:0]  w_phys;

    assign o_in_stall  = (r_step != lepr_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_o_valid;

    assign w_uw   = lepr_pkg::ucode(r_step);
    assign w_fire = !w_cond;

    assign w_n = (IW'(r_cfg) > IW'(MAX_EDGES)) ? IW'(MAX_EDGES) : IW'(r_cfg);

    always_comb begin
        w_rd = r_rd_data;
        if (!r_rd_vld) begin
            w_rd.leds = '0;
            w_rd.slot = lepr_pkg::SLOT_W'(r_rd_addr);
            w_rd.flip = 1'b0;
        end
    end

    assign w_hit      = HW'(r_pix) < (HW'(r_acc) + HW'(w_rd.leds));
    assign w_off_full = HW'(r_pix) - HW'(r_acc);
    assign w_off      = w_off_full[lepr_pkg::LEDS_W-1:0];

    assign w_start = r_flip ? (lepr_pkg::PIX_W'(r_base) + lepr_pkg::PIX_W'(r_cnt)
                               - lepr_pkg::PIX_W'(1))
                            : lepr_pkg::PIX_W'(r_base);
    assign w_phys  = lepr_pkg::PIX_W'(r_base) + lepr_pkg::PIX_W'(r_pos);

    // jump condition
    always_comb begin
        case (w_uw.cond)
            lepr_pkg::C_NEVER:     w_cond = 1'b0;
            lepr_pkg::C_NO_REQ:    w_cond = !i_in_valid;
            lepr_pkg::C_EDGE_OOR:  w_cond = IW'(r_edge) >= IW'(MAX_EDGES);
            lepr_pkg::C_WALK_STOP: w_cond = (r_walk_pend && w_hit) ||
                                            (!r_walk_pend && (IW'(r_scan) >= w_n));
            lepr_pkg::C_NO_HIT:    w_cond = !r_walk_pend;
            lepr_pkg::C_SUM_DONE:  w_cond = (IW'(r_scan) >= IW'(r_slot)) ||
                                            (IW'(r_scan) >= IW'(MAX_EDGES));
            lepr_pkg::C_OUT_BUSY:  w_cond = r_o_valid && i_out_stall;
            default:               w_cond = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        n_step = w_cond ? w_uw.jmp : w_uw.nxt;
        if (w_fire && (w_uw.act == lepr_pkg::A_ACCEPT)) begin
            n_step = lepr_pkg::op_entry(i_operation);
        end
    end

    // memory control
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_scan[AW-1:0];
        if (w_fire) begin
            case (w_uw.act)
                lepr_pkg::A_RD_EDGE: begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(r_edge);
                end
                lepr_pkg::A_WALK: w_rd_en = IW'(r_scan) < w_n;
                lepr_pkg::A_SUM:  w_rd_en = 1'b1;
                default:          w_rd_en = 1'b0;
            endcase
        end
        w_wr_en = w_fire && (w_uw.act == lepr_pkg::A_ACCEPT) &&
                  (i_operation == lepr_pkg::OP_WRITE) &&
                  (IW'(i_edge_index) < IW'(MAX_EDGES));
        w_wr_data.leds = i_led_total;
        w_wr_data.slot = i_strip_slot;
        w_wr_data.flip = i_reverse;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[AW'(i_edge_index)] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vld  <= r_vld[w_rd_addr];
            r_rd_addr <= w_rd_addr;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= lepr_pkg::ST_IDLE;
            r_vld       <= '0;
            r_cfg       <= lepr_pkg::CFG_RESET;
            r_walk_pend <= 1'b0;
            r_sum_pend  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_sum_pend <= w_fire && (w_uw.act == lepr_pkg::A_SUM);
            if (w_wr_en) begin
                r_vld[AW'(i_edge_index)] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (w_fire && (w_uw.act == lepr_pkg::A_ACCEPT)) begin
                r_walk_pend <= 1'b0;
            end else if (w_fire && (w_uw.act == lepr_pkg::A_WALK)) begin
                r_walk_pend <= w_rd_en;
            end else if (w_fire && (w_uw.act == lepr_pkg::A_LATCH_HIT)) begin
                r_walk_pend <= 1'b0;
            end
            if (w_fire && ((w_uw.act == lepr_pkg::A_EMIT) ||
                           (w_uw.act == lepr_pkg::A_EMIT_ZERO))) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_sum_pend) begin
            r_base <= r_base + SUMW'(w_rd.leds);
        end
        if (w_fire) begin
            case (w_uw.act)
                lepr_pkg::A_ACCEPT: begin
                    r_edge   <= i_edge_index;
                    r_pix    <= i_pixel_index;
                    r_is_pix <= (i_operation == lepr_pkg::OP_QPIX);
                    r_scan   <= '0;
                    r_acc    <= '0;
                    r_base   <= '0;
                end
                lepr_pkg::A_LATCH_Q: begin
                    r_cnt  <= w_rd.leds;
                    r_slot <= w_rd.slot;
                    r_flip <= w_rd.flip;
                end
                lepr_pkg::A_WALK: begin
                    if (r_walk_pend) begin
                        r_acc <= r_acc + SUMW'(w_rd.leds);
                    end
                    if (w_rd_en) begin
                        r_scan <= r_scan + CW'(1);
                    end
                end
                lepr_pkg::A_LATCH_HIT: begin
                    r_cnt  <= w_rd.leds;
                    r_slot <= w_rd.slot;
                    r_flip <= w_rd.flip;
                    r_edge <= lepr_pkg::EDGE_W'(r_rd_addr);
                    r_pos  <= w_rd.flip ? (w_rd.leds - lepr_pkg::LEDS_W'(1) - w_off) : w_off;
                    r_scan <= '0;
                end
                lepr_pkg::A_SUM: begin
                    r_scan <= r_scan + CW'(1);
                end
                lepr_pkg::A_EMIT: begin
                    o_found_edge  <= r_edge;
                    o_start_index <= w_start;
                    o_edge_leds   <= r_cnt;
                    o_direction   <= r_flip ? lepr_pkg::DIR_REV : lepr_pkg::DIR_FWD;
                    o_phys_index  <= r_is_pix ? w_phys : '0;
                    o_valid_res   <= r_is_pix ? 1'b1 : (IW'(r_edge) < w_n);
                end
                lepr_pkg::A_EMIT_ZERO: begin
                    o_found_edge  <= '0;
                    o_start_index <= '0;
                    o_edge_leds   <= '0;
                    o_direction   <= '0;
                    o_phys_index  <= '0;
                    o_valid_res   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    `LEPR_AST_IMP(a_walk_in_range, r_walk_pend, IW'(r_rd_addr) < w_n)
    `LEPR_AST_IMP(a_hit_at_select, (r_step == lepr_pkg::ST_WALK_SEL) && r_walk_pend, w_hit)
    `LEPR_AST_IMP(a_scan_le_slot, r_step == lepr_pkg::ST_SUM, IW'(r_scan) <= IW'(r_slot))
    `LEPR_AST_NXT(a_write_to_idle, w_wr_en, !o_in_stall)

endmodule

`default_nettype wire
